/* design/iwr_pkg.sv */
// Shared types and constants for the instruction window retire block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iwr_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int ADDR_BITS_DEF = 48;

  localparam int CFG_W = 4;
  localparam int RETIRED_W = 4;
  localparam int RETIRE_MAX = 8;

  localparam logic [CFG_W-1:0] RETIRE_WIDTH_RST = 4'd4;
  localparam logic [CFG_W-1:0] LINE_BITS_RST = 4'd6;

  localparam logic REG_RETIRE_WIDTH = 1'b0;
  localparam logic REG_LINE_BITS = 1'b1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_RETIRE = 2'd1;
  localparam logic [1:0] ACT_WAKE = 2'd2;

  typedef struct packed {
    logic load_item;
    logic insert;
    logic retire_step;
    logic wake_cmp;
    logic load_result;
  } iwr_cmd_t;

  typedef struct packed {
    logic retire_go;
    logic scan_done;
  } iwr_sts_t;

endpackage

`default_nettype wire

/* design/iwr_ctrl.sv */
// Controller state machine for the instruction window retire block.
// Depends on iwr_pkg for the action codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module iwr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       action,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output iwr_pkg::iwr_cmd_t     cmd,
  input  wire iwr_pkg::iwr_sts_t sts
);

  typedef enum logic [2:0] {
    IDLE,
    INSERT,
    RETIRE,
    WAKE_RD,
    WAKE_CMP,
    FINISH
  } state_t;

  state_t state;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == IDLE) || ((state == FINISH) && out_free));
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.load_item = accept;
    case (state)
      INSERT: cmd.insert = 1'b1;
      RETIRE: cmd.retire_step = sts.retire_go;
      WAKE_CMP: cmd.wake_cmp = 1'b1;
      FINISH: cmd.load_result = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE, FINISH: begin
          if (accept) begin
            case (action)
              iwr_pkg::ACT_INSERT: state <= INSERT;
              iwr_pkg::ACT_RETIRE: state <= RETIRE;
              iwr_pkg::ACT_WAKE: state <= WAKE_RD;
              default: state <= FINISH;
            endcase
          end else if ((state == FINISH) && out_free) begin
            state <= IDLE;
          end
        end
        INSERT: state <= FINISH;
        RETIRE: begin
          if (!sts.retire_go) begin
            state <= FINISH;
          end
        end
        WAKE_RD: begin
          if (sts.scan_done) begin
            state <= FINISH;
          end else begin
            state <= WAKE_CMP;
          end
        end
        WAKE_CMP: state <= WAKE_RD;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/iwr_datapath.sv */
// Datapath of the instruction window retire block: pointers, ready bits,
// address memory, configuration registers and the result word register.
// Depends on iwr_pkg for constants and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module iwr_datapath #(
  parameter int DEPTH = iwr_pkg::DEPTH_DEF,
  parameter int ADDR_BITS = iwr_pkg::ADDR_BITS_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire iwr_pkg::iwr_cmd_t             cmd,
  output iwr_pkg::iwr_sts_t                  sts,
  input  wire logic                          entry_ready,
  input  wire logic [ADDR_BITS-1:0]          address,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [iwr_pkg::CFG_W-1:0]     cfg_data,
  output logic [iwr_pkg::RETIRED_W-1:0]      retired_count,
  output logic [CW-1:0]                      occupancy,
  output logic                               is_full_now,
  output logic                               is_empty_now,
  output logic                               insert_dropped
);

  logic [AW-1:0]                 head;
  logic [AW-1:0]                 tail;
  logic [CW-1:0]                 count;
  logic [DEPTH-1:0]              ready_bits;
  logic [ADDR_BITS-1:0]          mem [DEPTH];
  logic [ADDR_BITS-1:0]          rd_data;
  logic                          item_ready;
  logic [ADDR_BITS-1:0]          item_addr;
  logic [iwr_pkg::RETIRED_W-1:0] retired;
  logic                          dropped;
  logic [iwr_pkg::CFG_W-1:0]     retire_width;
  logic [iwr_pkg::CFG_W-1:0]     line_bits;
  logic [AW-1:0]                 scan_ptr;
  logic [CW-1:0]                 scan_left;
  logic [iwr_pkg::RETIRED_W-1:0] limit;
  logic [ADDR_BITS-1:0]          line_mask;
  logic                          full;
  logic                          line_match;

  function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (count == CW'(DEPTH));
  assign limit = (retire_width > iwr_pkg::CFG_W'(iwr_pkg::RETIRE_MAX))
               ? iwr_pkg::RETIRED_W'(iwr_pkg::RETIRE_MAX)
               : iwr_pkg::RETIRED_W'(retire_width);
  assign line_mask = {ADDR_BITS{1'b1}} << line_bits;
  assign line_match = ((rd_data & line_mask) == (item_addr & line_mask));

  assign sts.retire_go = (count != '0) && (retired < limit) && ready_bits[tail];
  assign sts.scan_done = (scan_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      retire_width <= iwr_pkg::RETIRE_WIDTH_RST;
      line_bits <= iwr_pkg::LINE_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        iwr_pkg::REG_RETIRE_WIDTH: retire_width <= cfg_data;
        iwr_pkg::REG_LINE_BITS: line_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      ready_bits <= '0;
    end else begin
      if (cmd.insert && !full) begin
        ready_bits[head] <= item_ready;
        head <= step_ptr(head);
        count <= count + 1'b1;
      end else if (cmd.retire_step) begin
        tail <= step_ptr(tail);
        count <= count - 1'b1;
      end else if (cmd.wake_cmp && line_match) begin
        ready_bits[scan_ptr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_ptr];
    if (cmd.insert && !full) begin
      mem[head] <= item_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_ready <= entry_ready;
      item_addr <= address;
      retired <= '0;
      dropped <= 1'b0;
      scan_ptr <= tail;
      scan_left <= count;
    end else begin
      if (cmd.insert) begin
        dropped <= full;
      end
      if (cmd.retire_step) begin
        retired <= retired + 1'b1;
      end
      if (cmd.wake_cmp) begin
        scan_ptr <= step_ptr(scan_ptr);
        scan_left <= scan_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      retired_count <= retired;
      occupancy <= count;
      is_full_now <= full;
      is_empty_now <= (count == '0);
      insert_dropped <= dropped;
    end
  end

endmodule

`default_nettype wire

/* design/instruction_window_retire.sv */
// Instruction window retire block: a circular window of DEPTH entries that
// takes insert, retire and wake words and returns one status word for each.
// Channels: the input channel (in_valid, in_stall, action, entry_ready,
// address) and the output channel (out_valid, out_stall and the status
// fields) move a word when valid is high and stall is low. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes retire_width at
// index 0 and line_bits at index 1, and is always ready.
// Sequencing: an insert passes the INSERT and FINISH states from accept to the
// result register and an unused action goes straight to FINISH; a retire stays
// in RETIRE while the tail entry is ready, retiring one entry per step (at most
// 8); a wake alternates WAKE_RD and WAKE_CMP for each occupied entry, since the
// address memory has one registered read port and each entry needs a read and
// a compare step. One word is in work at a time. The next input word is taken in
// the cycle its predecessor's result is loaded.
// Reset empties the window, clears all ready bits, and restores retire_width
// to 4 and line_bits to 6. While the receiver stalls, the result is held and
// a finished word waits in the controller until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module instruction_window_retire #(
  parameter int DEPTH = iwr_pkg::DEPTH_DEF,
  parameter int ADDR_BITS = iwr_pkg::ADDR_BITS_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  action,
  input  wire logic                        entry_ready,
  input  wire logic [ADDR_BITS-1:0]        address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [iwr_pkg::RETIRED_W-1:0]    retired_count,
  output logic [CW-1:0]                    occupancy,
  output logic                             is_full_now,
  output logic                             is_empty_now,
  output logic                             insert_dropped,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [iwr_pkg::CFG_W-1:0]   cfg_data
);

  iwr_pkg::iwr_cmd_t cmd;
  iwr_pkg::iwr_sts_t sts;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  iwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  iwr_datapath #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .entry_ready    (entry_ready),
    .address        (address),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .retired_count  (retired_count),
    .occupancy      (occupancy),
    .is_full_now    (is_full_now),
    .is_empty_now   (is_empty_now),
    .insert_dropped (insert_dropped)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
      (action == iwr_pkg::ACT_INSERT || action == iwr_pkg::ACT_RETIRE ||
       action == iwr_pkg::ACT_WAKE)
      |=> in_stall)
    else $error("input accepted in the cycle after an accept");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_full_now && is_empty_now) && (occupancy <= CW'(DEPTH)))
    else $error("result word reports an impossible occupancy");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && insert_dropped |-> is_full_now && (retired_count == '0))
    else $error("dropped insert reported without a full window");

  a_retire_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (retired_count != '0)
      |-> !is_full_now && (retired_count <= iwr_pkg::RETIRED_W'(iwr_pkg::RETIRE_MAX)))
    else $error("retired count out of range");
`endif

endmodule

`default_nettype wire

/* sim/instruction_window_retire_test.sv */
// Self-checking testbench for instruction_window_retire: insert, retire and wake words
// with random gaps and stalls, each status word checked against a behavioral window copy.
// Depends on iwr_pkg and the instruction_window_retire design only.
`timescale 1ns / 1ps

module instruction_window_retire_test;

  localparam int DEPTH = iwr_pkg::DEPTH_DEF;
  localparam int ADDR_BITS = iwr_pkg::ADDR_BITS_DEF;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [iwr_pkg::RETIRED_W-1:0] retired;
    logic [OCC_W-1:0] occ;
    logic full;
    logic empty;
    logic dropped;
  } window_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = iwr_pkg::ACT_INSERT;
  logic entry_ready = 1'b0;
  logic [ADDR_BITS-1:0] address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [iwr_pkg::RETIRED_W-1:0] retired_count;
  logic [OCC_W-1:0] occupancy;
  logic is_full_now;
  logic is_empty_now;
  logic insert_dropped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = iwr_pkg::REG_RETIRE_WIDTH;
  logic [iwr_pkg::CFG_W-1:0] cfg_data = '0;

  logic win_ready [DEPTH] = '{default: 1'b0};
  logic [ADDR_BITS-1:0] win_addr [DEPTH];
  int win_head = 0;
  int win_tail = 0;
  int win_count = 0;
  logic [iwr_pkg::CFG_W-1:0] win_width = iwr_pkg::RETIRE_WIDTH_RST;
  logic [iwr_pkg::CFG_W-1:0] win_line_bits = iwr_pkg::LINE_BITS_RST;

  window_status_t status_due [$];
  logic [ADDR_BITS-1:0] line_pool [8];
  int err_count = 0;
  int stall_left = 0;
  bit tx_calm = 1'b1;
  bit rx_calm = 1'b1;

  instruction_window_retire dut (
    .clk, .rst, .in_valid, .in_stall, .action, .entry_ready, .address,
    .out_valid, .out_stall, .retired_count, .occupancy, .is_full_now,
    .is_empty_now, .insert_dropped, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  function automatic window_status_t window_step(logic [1:0] act, logic rdy,
                                                 logic [ADDR_BITS-1:0] addr);
    window_status_t st;
    int lim;
    int n;
    int idx;
    int i;
    logic [ADDR_BITS-1:0] line;
    st = '0;
    n = 0;
    if (act == iwr_pkg::ACT_INSERT) begin
      if (win_count >= DEPTH) begin
        st.dropped = 1'b1;
      end else begin
        win_ready[win_head] = rdy;
        win_addr[win_head] = addr;
        win_head = (win_head + 1) % DEPTH;
        win_count++;
      end
    end else if (act == iwr_pkg::ACT_RETIRE) begin
      lim = (win_width > iwr_pkg::RETIRE_MAX) ? iwr_pkg::RETIRE_MAX : int'(win_width);
      while (win_count > 0 && n < lim && win_ready[win_tail]) begin
        win_tail = (win_tail + 1) % DEPTH;
        win_count--;
        n++;
      end
    end else if (act == iwr_pkg::ACT_WAKE) begin
      line = addr >> win_line_bits;
      idx = win_tail;
      for (i = 0; i < win_count; i++) begin
        if ((win_addr[idx] >> win_line_bits) == line) begin
          win_ready[idx] = 1'b1;
        end
        idx = (idx + 1) % DEPTH;
      end
    end
    st.retired = n[iwr_pkg::RETIRED_W-1:0];
    st.occ = win_count[OCC_W-1:0];
    st.full = (win_count == DEPTH);
    st.empty = (win_count == 0);
    return st;
  endfunction

  function automatic int burst_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ADDR_BITS-1:0] random_address();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] pool_address();
    logic [ADDR_BITS-1:0] a;
    a = line_pool[$urandom_range(0, 7)];
    a[15:0] = 16'($urandom());
    return a;
  endfunction

  function automatic logic [ADDR_BITS-1:0] line_twin(logic [ADDR_BITS-1:0] addr);
    logic [ADDR_BITS-1:0] mask;
    mask = (ADDR_BITS'(1) << win_line_bits) - 1'b1;
    return addr ^ (random_address() & mask);
  endfunction

  function automatic logic [ADDR_BITS-1:0] wake_target();
    int idx;
    if (win_count == 0 || $urandom_range(0, 3) == 0) return pool_address();
    if ($urandom_range(0, 1) == 0) begin
      idx = win_tail;
    end else begin
      idx = (win_tail + $urandom_range(0, win_count - 1)) % DEPTH;
    end
    return line_twin(win_addr[idx]);
  endfunction

  task automatic refresh_pool();
    foreach (line_pool[i]) line_pool[i] = random_address();
  endtask

  task automatic push_word(logic [1:0] act, logic rdy, logic [ADDR_BITS-1:0] addr);
    int gap;
    gap = tx_calm ? 0 : burst_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    entry_ready <= rdy;
    address <= addr;
    do @(posedge clk); while (in_stall !== 1'b0);
    status_due.push_back(window_step(act, rdy, addr));
  endtask

  task automatic settle_window();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window_config(logic [iwr_pkg::CFG_W-1:0] width,
                                   logic [iwr_pkg::CFG_W-1:0] lbits);
    cfg_valid <= 1'b1;
    cfg_index <= iwr_pkg::REG_RETIRE_WIDTH;
    cfg_data <= width;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    win_width = width;
    cfg_index <= iwr_pkg::REG_LINE_BITS;
    cfg_data <= lbits;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    win_line_bits = lbits;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_status();
    window_status_t want;
    if (status_due.size() == 0) begin
      err_count++;
      $display("%0t: status word with none expected, expected nothing actual occupancy %0d",
               $time, occupancy);
    end else begin
      want = status_due.pop_front();
      check_field("retired_count", 16'(want.retired), 16'(retired_count));
      check_field("occupancy", 16'(want.occ), 16'(occupancy));
      check_field("is_full_now", 16'(want.full), 16'(is_full_now));
      check_field("is_empty_now", 16'(want.empty), 16'(is_empty_now));
      check_field("insert_dropped", 16'(want.dropped), 16'(insert_dropped));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      check_status();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_calm || $urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = burst_gap();
      out_stall <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Empty-window cases, a load that blocks retirement until its line is woken,
  // zero and oversized retire widths, and the widest line match.
  task automatic test_directed_cases();
    push_word(iwr_pkg::ACT_RETIRE, 1'b0, '0);
    push_word(iwr_pkg::ACT_WAKE, 1'b1, '0);
    push_word(ACT_UNUSED, 1'b1, '1);
    push_word(iwr_pkg::ACT_INSERT, 1'b1, '0);
    push_word(iwr_pkg::ACT_INSERT, 1'b0, '1);
    push_word(iwr_pkg::ACT_INSERT, 1'b1, 48'h40);
    push_word(iwr_pkg::ACT_RETIRE, 1'b0, '0);
    push_word(ACT_UNUSED, 1'b0, 48'h5555_5555_5555);
    push_word(iwr_pkg::ACT_WAKE, 1'b0, 48'hFFFF_FFFF_FFC0);
    push_word(iwr_pkg::ACT_RETIRE, 1'b1, '1);
    settle_window();
    set_window_config(4'd0, 4'd15);
    push_word(iwr_pkg::ACT_INSERT, 1'b1, 48'h1234);
    push_word(iwr_pkg::ACT_RETIRE, 1'b0, '0);
    push_word(iwr_pkg::ACT_INSERT, 1'b0, 48'h7FFF);
    push_word(iwr_pkg::ACT_WAKE, 1'b0, 48'h0);
    settle_window();
    set_window_config(4'd15, 4'd15);
    repeat (10) push_word(iwr_pkg::ACT_INSERT, 1'b1, random_address());
    repeat (3) push_word(iwr_pkg::ACT_RETIRE, 1'b0, '0);
  endtask

  task automatic test_full_window();
    settle_window();
    set_window_config(4'd1, 4'd12);
    refresh_pool();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    while (win_count < DEPTH) push_word(iwr_pkg::ACT_INSERT, 1'($urandom()), pool_address());
    repeat (3) push_word(iwr_pkg::ACT_INSERT, 1'($urandom()), random_address());
    push_word(ACT_UNUSED, 1'($urandom()), random_address());
    while (win_count > 0) begin
      if (win_ready[win_tail]) begin
        push_word(iwr_pkg::ACT_RETIRE, 1'($urandom()), random_address());
      end else begin
        push_word(iwr_pkg::ACT_WAKE, 1'($urandom()), line_twin(win_addr[win_tail]));
      end
    end
  endtask

  task automatic test_random_traffic(logic [iwr_pkg::CFG_W-1:0] width,
                                     logic [iwr_pkg::CFG_W-1:0] lbits, int count);
    int k;
    int r;
    int hi_mark;
    int lo_mark;
    bit filling;
    settle_window();
    set_window_config(width, lbits);
    refresh_pool();
    filling = 1'b1;
    hi_mark = $urandom_range(4, 48);
    lo_mark = 0;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (filling && (win_count >= hi_mark ||
                      (win_count == DEPTH && $urandom_range(0, 7) == 0))) begin
        filling = 1'b0;
        lo_mark = $urandom_range(0, 8);
      end else if (!filling && win_count <= lo_mark) begin
        filling = 1'b1;
        hi_mark = ($urandom_range(0, 3) == 0) ? DEPTH + 4 : $urandom_range(4, 48);
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_word(ACT_UNUSED, 1'($urandom()), random_address());
      end else if (r < 9) begin
        push_word(2'($urandom_range(0, 3)), 1'($urandom()), random_address());
      end else if (r < (filling ? 70 : 25)) begin
        push_word(iwr_pkg::ACT_INSERT, 1'($urandom()), pool_address());
      end else if (r < (filling ? 85 : 70)) begin
        push_word(iwr_pkg::ACT_RETIRE, 1'($urandom()), random_address());
      end else begin
        push_word(iwr_pkg::ACT_WAKE, 1'($urandom()), wake_target());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_window();
    test_random_traffic(iwr_pkg::RETIRE_WIDTH_RST, iwr_pkg::LINE_BITS_RST, 200);
    test_random_traffic(4'd8, 4'd0, 200);
    test_random_traffic(4'd1, 4'd12, 200);
    test_random_traffic(4'd0, 4'd3, 120);
    test_random_traffic(4'd15, 4'd15, 200);
    test_random_traffic(4'd9, 4'd13, 200);
    test_random_traffic(4'($urandom_range(1, 8)), 4'($urandom_range(0, 12)), 180);
    settle_window();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
